>>> src/pcc_pkg.sv
// shared types, codes and helpers for the clamped pid controller
package pcc_pkg;

  localparam int unsigned QFRAC   = 16;
  localparam int unsigned GAIN_W  = 31;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned DIFF_W  = VAL_W + 1;
  localparam int unsigned PROD_W  = GAIN_W + 1 + DIFF_W;
  localparam int unsigned SUM_W   = PROD_W + 2;
  localparam int unsigned CADDR_W = 3;
  localparam int unsigned CDATA_W = GAIN_W;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_AUTO   = 2'd1,
    OP_MANUAL = 2'd2
  } pcc_op_t;

  typedef enum logic [CADDR_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_OUT_LOW     = 3'd3,
    REG_OUT_HIGH    = 3'd4,
    REG_PERIOD_MS   = 3'd5,
    REG_REVERSE_DIR = 3'd6
  } pcc_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0]       prop_gain;
    logic [GAIN_W-1:0]       integ_gain;
    logic [GAIN_W-1:0]       deriv_gain;
    logic signed [VAL_W-1:0] out_low;
    logic signed [VAL_W-1:0] out_high;
    logic [VAL_W-1:0]        period_ms;
    logic                    reverse_dir;
  } pcc_cfg_t;

  typedef struct packed {
    logic [1:0]              operation;
    logic [TIME_W-1:0]       now_ms;
    logic signed [VAL_W-1:0] measured;
    logic signed [VAL_W-1:0] target;
    logic signed [VAL_W-1:0] held_output;
  } pcc_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] integ_acc;
    logic signed [VAL_W-1:0] prev_measured;
    logic [TIME_W-1:0]       last_run_ms;
    logic                    first_due;
    logic                    auto_on;
    logic signed [VAL_W-1:0] drive;
  } pcc_state_t;

  // clamp a q35.16 sum to the limits and return it as q16.16, upper limit tested first
  function automatic logic signed [ACC_W-1:0] clamp_q(
    input logic signed [SUM_W-1:0] v,
    input logic signed [VAL_W-1:0] lo,
    input logic signed [VAL_W-1:0] hi
  );
    logic signed [SUM_W-1:0] hq;
    logic signed [SUM_W-1:0] lq;
    logic signed [SUM_W-1:0] r;
    hq = {{(SUM_W-VAL_W-QFRAC){hi[VAL_W-1]}}, hi, {QFRAC{1'b0}}};
    lq = {{(SUM_W-VAL_W-QFRAC){lo[VAL_W-1]}}, lo, {QFRAC{1'b0}}};
    if (v > hq) begin
      r = hq;
    end else if (v < lq) begin
      r = lq;
    end else begin
      r = v;
    end
    return r[ACC_W-1:0];
  endfunction

endpackage

>>> src/pcc_step.sv
// one update of the controller state for one input word
module pcc_step (
  input  pcc_pkg::pcc_cfg_t   cfg,
  input  pcc_pkg::pcc_item_t  item,
  input  pcc_pkg::pcc_state_t st,
  output pcc_pkg::pcc_state_t st_nxt,
  output logic                updated
);
  import pcc_pkg::*;

  logic signed [DIFF_W-1:0] err_raw;
  logic signed [DIFF_W-1:0] din_raw;
  logic signed [DIFF_W-1:0] err;
  logic signed [DIFF_W-1:0] din;
  logic signed [PROD_W-1:0] p_prop;
  logic signed [PROD_W-1:0] p_integ;
  logic signed [PROD_W-1:0] p_deriv;
  logic signed [SUM_W-1:0]  integ_sum;
  logic signed [ACC_W-1:0]  integ_new;
  logic signed [SUM_W-1:0]  out_sum;
  logic signed [ACC_W-1:0]  out_clamped;
  logic signed [SUM_W-1:0]  seed_q;
  logic [TIME_W-1:0]        elapsed;
  logic                     due;

  assign err_raw = {item.target[VAL_W-1], item.target}
                 - {item.measured[VAL_W-1], item.measured};
  assign din_raw = {item.measured[VAL_W-1], item.measured}
                 - {st.prev_measured[VAL_W-1], st.prev_measured};
  assign err = cfg.reverse_dir ? -err_raw : err_raw;
  assign din = cfg.reverse_dir ? -din_raw : din_raw;

  // three gain products in parallel
  assign p_prop  = $signed({1'b0, cfg.prop_gain})  * err;
  assign p_integ = $signed({1'b0, cfg.integ_gain}) * err;
  assign p_deriv = $signed({1'b0, cfg.deriv_gain}) * din;

  assign integ_sum   = SUM_W'(p_integ) + SUM_W'(st.integ_acc);
  assign integ_new   = clamp_q(integ_sum, cfg.out_low, cfg.out_high);
  assign out_sum     = SUM_W'(p_prop) + SUM_W'(integ_new) - SUM_W'(p_deriv);
  assign out_clamped = clamp_q(out_sum, cfg.out_low, cfg.out_high);

  assign seed_q = {{(SUM_W-VAL_W-QFRAC){item.held_output[VAL_W-1]}},
                   item.held_output, {QFRAC{1'b0}}};

  assign elapsed = item.now_ms - st.last_run_ms;
  assign due     = st.first_due || (elapsed >= {{(TIME_W-VAL_W){1'b0}}, cfg.period_ms});

  always_comb begin
    st_nxt  = st;
    updated = 1'b0;
    unique case (item.operation)
      OP_TICK: begin
        if (st.auto_on && due) begin
          st_nxt.integ_acc     = integ_new;
          // floor of q16.16 is the integer part of the two's complement word
          st_nxt.drive         = out_clamped[ACC_W-1:QFRAC];
          st_nxt.prev_measured = item.measured;
          st_nxt.last_run_ms   = item.now_ms;
          st_nxt.first_due     = 1'b0;
          updated              = 1'b1;
        end
      end
      OP_AUTO: begin
        if (!st.auto_on) begin
          st_nxt.integ_acc     = clamp_q(seed_q, cfg.out_low, cfg.out_high);
          st_nxt.prev_measured = item.measured;
        end
        st_nxt.auto_on = 1'b1;
      end
      OP_MANUAL: begin
        st_nxt.auto_on = 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> src/pid_controller_clamped_unit.sv
// top level of the clamped pid controller with derivative on measurement
//
// Sampled PID regulator. Each input word is a sample tick, a switch to
// automatic or a switch to manual, and every input word yields exactly one
// output word: a flag telling whether a new drive value was computed and
// the latest clamped drive. Words are taken one per clock cycle while the
// result stream does not stall; an accepted word goes through the input
// register, then the result register. The rate is set by the controller
// state loop: the integrator, last measurement, last run time and drive are
// updated in the same cycle that the gain products are formed, so each word
// sees the state left by the word before it. Gains are unsigned Q15.16, the
// integrator is signed Q16.16 and the sum is floored after clamping. Configuration
// writes take effect on the next cycle and are meant to be done while idle.
module pid_controller_clamped_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [79:0]                 in_tdata,  // now_ms, measured, target, held_output
  input  logic [1:0]                  in_tuser,  // operation
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata, // drive
  output logic                        out_tuser, // updated
  // configuration writes
  input  logic                        cfg_wen,
  input  logic [pcc_pkg::CADDR_W-1:0] cfg_addr,
  input  logic [pcc_pkg::CDATA_W-1:0] cfg_wdata
);
  import pcc_pkg::*;

  pcc_cfg_t   cfg_r;
  pcc_item_t  item_r;
  logic       item_valid_r;
  pcc_state_t st_r;
  pcc_state_t st_nxt;
  logic       updated;
  logic       out_valid_r;
  logic       out_upd_r;
  logic [VAL_W-1:0] out_drive_r;
  logic       advance;

  // the held word moves on when the result register is free or being drained
  assign advance   = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain   <= GAIN_W'(167117);
      cfg_r.integ_gain  <= '0;
      cfg_r.deriv_gain  <= '0;
      cfg_r.out_low     <= '0;
      cfg_r.out_high    <= VAL_W'(255);
      cfg_r.period_ms   <= VAL_W'(100);
      cfg_r.reverse_dir <= 1'b0;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_PROP_GAIN:   cfg_r.prop_gain   <= cfg_wdata;
        REG_INTEG_GAIN:  cfg_r.integ_gain  <= cfg_wdata;
        REG_DERIV_GAIN:  cfg_r.deriv_gain  <= cfg_wdata;
        REG_OUT_LOW:     cfg_r.out_low     <= cfg_wdata[VAL_W-1:0];
        REG_OUT_HIGH:    cfg_r.out_high    <= cfg_wdata[VAL_W-1:0];
        REG_PERIOD_MS:   cfg_r.period_ms   <= cfg_wdata[VAL_W-1:0];
        REG_REVERSE_DIR: cfg_r.reverse_dir <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.operation   <= in_tuser;
      item_r.now_ms      <= in_tdata[31:0];
      item_r.measured    <= in_tdata[47:32];
      item_r.target      <= in_tdata[63:48];
      item_r.held_output <= in_tdata[79:64];
    end
  end

  pcc_step u_step (
    .cfg     (cfg_r),
    .item    (item_r),
    .st      (st_r),
    .st_nxt  (st_nxt),
    .updated (updated)
  );

  // controller state, committed once per word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.integ_acc     <= '0;
      st_r.prev_measured <= '0;
      st_r.last_run_ms   <= '0;
      st_r.first_due     <= 1'b1;
      st_r.auto_on       <= 1'b1;
      st_r.drive         <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_upd_r   <= updated;
      out_drive_r <= st_nxt.drive;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_drive_r;
  assign out_tuser  = out_upd_r;

endmodule
